FILE: rtl/lah_pkg.sv
// Shared types and constants for the LAND attack host table.
package lah_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic ACT_PACKET   = 1'b0;
   localparam logic ACT_DUMP     = 1'b1;
   localparam logic STATUS_ENTRY = 1'b0;
   localparam logic STATUS_DROP  = 1'b1;

   localparam logic [31:0] TALLY_MAX = 32'hFFFF_FFFF;

   // classified word passed from front to back
   typedef struct packed {
      logic        dump;
      logic [31:0] ip;
      logic [5:0]  minute;
      logic [5:0]  second;
   } lah_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE,
      ST_DROP,
      ST_DUMP
   } lah_state_type;

endpackage

FILE: rtl/lah_front.sv
// Front end: accepts request words, drops non-LAND packets, queues the rest.
module lah_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [31:0]          req_src_ip,
   input  logic [31:0]          req_dst_ip,
   input  logic [5:0]           req_minute,
   input  logic [5:0]           req_second,
   output logic                 q_valid,
   output lah_pkg::lah_item_type q_item,
   input  logic                 q_pop
);

   lah_pkg::lah_item_type              queue_ff [lah_pkg::QUEUE_DEPTH];
   logic [lah_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [lah_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [lah_pkg::QCNT_W-1:0]         fill_ff, fill_in;
   logic                               accept;
   logic                               push;
   logic                               pop;
   lah_pkg::lah_item_type              new_item;

   assign req_stall = (fill_ff == lah_pkg::QCNT_W'(lah_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   // only dumps and LAND packets reach the table
   assign push      = accept &&
                      ((req_action == lah_pkg::ACT_DUMP) || (req_src_ip == req_dst_ip));
   assign q_valid   = (fill_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];
   assign pop       = q_pop && q_valid;

   always_comb begin
      new_item.dump   = (req_action == lah_pkg::ACT_DUMP);
      new_item.ip     = req_dst_ip;
      new_item.minute = req_minute;
      new_item.second = req_second;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lah_pkg::QPTR_W'(lah_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + lah_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lah_pkg::QPTR_W'(lah_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + lah_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + lah_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - lah_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= lah_pkg::QCNT_W'(lah_pkg::QUEUE_DEPTH))
      else $error("queue fill out of range");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == lah_pkg::ACT_PACKET) && (req_src_ip != req_dst_ip) && !pop)
      |=> $stable(fill_ff))
      else $error("non-LAND packet entered queue");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

FILE: rtl/lah_back.sv
// Back end: host table, lookup/update sequencer, dump walker and result register.
module lah_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  lah_pkg::lah_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output logic [31:0]           rsp_host_ip,
   output logic [5:0]            rsp_start_minute,
   output logic [5:0]            rsp_start_second,
   output logic [5:0]            rsp_end_minute,
   output logic [5:0]            rsp_end_second,
   output logic [31:0]           rsp_hit_count,
   output logic                  rsp_last
);

   localparam int D = lah_pkg::TABLE_DEPTH;

   logic [31:0] host_addr_ff    [D];
   logic [5:0]  first_min_ff    [D];
   logic [5:0]  first_sec_ff    [D];
   logic [5:0]  latest_min_ff   [D];
   logic [5:0]  latest_sec_ff   [D];
   logic [31:0] packet_tally_ff [D];

   lah_pkg::lah_state_type      state_ff, state_in;
   lah_pkg::lah_item_type       cur_ff, cur_in;
   logic [lah_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [lah_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [D-1:0]                hit_ff, hit_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_host_ip_ff, rsp_host_ip_in;
   logic [5:0]  rsp_start_minute_ff, rsp_start_minute_in;
   logic [5:0]  rsp_start_second_ff, rsp_start_second_in;
   logic [5:0]  rsp_end_minute_ff, rsp_end_minute_in;
   logic [5:0]  rsp_end_second_ff, rsp_end_second_in;
   logic [31:0] rsp_hit_count_ff, rsp_hit_count_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                       out_free;
   logic                       load_out;
   logic                       do_hit;
   logic                       do_append;
   logic [lah_pkg::IDX_W-1:0]  app_idx;
   logic [D-1:0]               match;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign app_idx  = count_ff[lah_pkg::IDX_W-1:0];

   // parallel compare against every live entry
   always_comb begin
      for (int i = 0; i < D; i++) begin
         match[i] = (lah_pkg::CNT_W'(i) < count_ff) && (host_addr_ff[i] == cur_ff.ip);
      end
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      q_pop     = 1'b0;
      load_out  = 1'b0;
      do_hit    = 1'b0;
      do_append = 1'b0;

      rsp_status_in       = rsp_status_ff;
      rsp_host_ip_in      = rsp_host_ip_ff;
      rsp_start_minute_in = rsp_start_minute_ff;
      rsp_start_second_in = rsp_start_second_ff;
      rsp_end_minute_in   = rsp_end_minute_ff;
      rsp_end_second_in   = rsp_end_second_ff;
      rsp_hit_count_in    = rsp_hit_count_ff;
      rsp_last_in         = rsp_last_ff;

      unique case (state_ff)
         lah_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               idx_in = '0;
               if (!q_item.dump) begin
                  state_in = lah_pkg::ST_MATCH;
               end else if (count_ff != '0) begin
                  state_in = lah_pkg::ST_DUMP;
               end
            end
         end
         lah_pkg::ST_MATCH: begin
            hit_in   = match;
            state_in = lah_pkg::ST_UPDATE;
         end
         lah_pkg::ST_UPDATE: begin
            if (hit_ff != '0) begin
               do_hit   = 1'b1;
               state_in = lah_pkg::ST_IDLE;
            end else if (count_ff < lah_pkg::CNT_W'(D)) begin
               do_append = 1'b1;
               count_in  = count_ff + lah_pkg::CNT_W'(1);
               state_in  = lah_pkg::ST_IDLE;
            end else begin
               state_in = lah_pkg::ST_DROP;
            end
         end
         lah_pkg::ST_DROP: begin
            if (out_free) begin
               load_out            = 1'b1;
               rsp_status_in       = lah_pkg::STATUS_DROP;
               rsp_host_ip_in      = cur_ff.ip;
               rsp_start_minute_in = cur_ff.minute;
               rsp_start_second_in = cur_ff.second;
               rsp_end_minute_in   = cur_ff.minute;
               rsp_end_second_in   = cur_ff.second;
               rsp_hit_count_in    = '0;
               rsp_last_in         = 1'b1;
               state_in            = lah_pkg::ST_IDLE;
            end
         end
         lah_pkg::ST_DUMP: begin
            if (out_free) begin
               load_out            = 1'b1;
               rsp_status_in       = lah_pkg::STATUS_ENTRY;
               rsp_host_ip_in      = host_addr_ff[idx_ff];
               rsp_start_minute_in = first_min_ff[idx_ff];
               rsp_start_second_in = first_sec_ff[idx_ff];
               rsp_end_minute_in   = latest_min_ff[idx_ff];
               rsp_end_second_in   = latest_sec_ff[idx_ff];
               rsp_hit_count_in    = packet_tally_ff[idx_ff];
               rsp_last_in = (lah_pkg::CNT_W'(idx_ff) + lah_pkg::CNT_W'(1) == count_ff);
               if (rsp_last_in) begin
                  count_in = '0;
                  state_in = lah_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + lah_pkg::IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = lah_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lah_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff              <= cur_in;
      idx_ff              <= idx_in;
      hit_ff              <= hit_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_host_ip_ff      <= rsp_host_ip_in;
      rsp_start_minute_ff <= rsp_start_minute_in;
      rsp_start_second_ff <= rsp_start_second_in;
      rsp_end_minute_ff   <= rsp_end_minute_in;
      rsp_end_second_ff   <= rsp_end_second_in;
      rsp_hit_count_ff    <= rsp_hit_count_in;
      rsp_last_ff         <= rsp_last_in;
   end

   // table entries: append at the fill point, or refresh the matching host
   always_ff @(posedge clock) begin
      for (int i = 0; i < D; i++) begin
         if (do_append && (app_idx == lah_pkg::IDX_W'(i))) begin
            host_addr_ff[i]    <= cur_ff.ip;
            first_min_ff[i]    <= cur_ff.minute;
            first_sec_ff[i]    <= cur_ff.second;
            latest_min_ff[i]   <= cur_ff.minute;
            latest_sec_ff[i]   <= cur_ff.second;
            packet_tally_ff[i] <= 32'd1;
         end else if (do_hit && hit_ff[i]) begin
            latest_min_ff[i] <= cur_ff.minute;
            latest_sec_ff[i] <= cur_ff.second;
            if (packet_tally_ff[i] != lah_pkg::TALLY_MAX) begin
               packet_tally_ff[i] <= packet_tally_ff[i] + 32'd1;
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_host_ip      = rsp_host_ip_ff;
   assign rsp_start_minute = rsp_start_minute_ff;
   assign rsp_start_second = rsp_start_second_ff;
   assign rsp_end_minute   = rsp_end_minute_ff;
   assign rsp_end_second   = rsp_end_second_ff;
   assign rsp_hit_count    = rsp_hit_count_ff;
   assign rsp_last         = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= lah_pkg::CNT_W'(D))
      else $error("entry count above table depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lah_pkg::ST_UPDATE) |-> $onehot0(hit_ff))
      else $error("host present in more than one entry");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lah_pkg::ST_DROP) |-> (count_ff == lah_pkg::CNT_W'(D)))
      else $error("drop issued with room in table");

   assert property (@(posedge clock) disable iff (reset)
      (load_out && rsp_last_in && (state_ff == lah_pkg::ST_DUMP)) |=> (count_ff == '0))
      else $error("table not cleared after dump");

endmodule

FILE: rtl/land_attack_host_table_top.sv
// Top level of the LAND attack host table: front classifier, queue and table engine.
//
//  channel  dir  handshake        payload
//  req_     in   valid / stall    action, src_ip, dst_ip, minute, second
//  rsp_     out  valid / stall    status, host_ip, start/end minute/second, hit_count, last
//
//  A LAND packet passes the table engine through pop, parallel compare and update;
//  a full-table drop adds a state for its result word. Other packets are discarded in the front.
//  A dump pops its word, then sends one entry per cycle while the output register is free.
//  A 2-word queue in the front takes words while the engine works or rsp_ stalls, until full.
//  Synchronous reset empties the queue and the table; no clearing pass is needed.
module land_attack_host_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [31:0] rsp_host_ip,
   output logic [5:0]  rsp_start_minute,
   output logic [5:0]  rsp_start_second,
   output logic [5:0]  rsp_end_minute,
   output logic [5:0]  rsp_end_second,
   output logic [31:0] rsp_hit_count,
   output logic        rsp_last
);

   logic                  q_valid;
   logic                  q_pop;
   lah_pkg::lah_item_type q_item;

   lah_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_src_ip (req_src_ip),
      .req_dst_ip (req_dst_ip),
      .req_minute (req_minute),
      .req_second (req_second),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   lah_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_host_ip      (rsp_host_ip),
      .rsp_start_minute (rsp_start_minute),
      .rsp_start_second (rsp_start_second),
      .rsp_end_minute   (rsp_end_minute),
      .rsp_end_second   (rsp_end_second),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_last         (rsp_last)
   );

endmodule
